FILE: rtl/core/balance_line_follow_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// balance_line_follow_controller_unit_macros
// assertion macros shared by the checker
// ---------------------------------------------------------------------------
`ifndef BALANCE_LINE_FOLLOW_CONTROLLER_UNIT_MACROS_SVH
`define BALANCE_LINE_FOLLOW_CONTROLLER_UNIT_MACROS_SVH

// checked only outside reset
`define BLFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BLFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/blfc_pkg.sv
// ---------------------------------------------------------------------------
// blfc_pkg
// types, constants and helpers of the balance and line follow controller
// ---------------------------------------------------------------------------
package blfc_pkg;

    localparam int SENSOR_COUNT  = 4;
    localparam int ADC_BITS      = 12;
    localparam int SIDX_W        = $clog2(SENSOR_COUNT);
    localparam int RAW_LOW       = 1700;
    localparam int RAW_HIGH      = 4000;
    localparam int VAL_W         = 10;
    localparam int SEEN_LEVEL    = 400;
    // floor(10*x/23) == (x*RECIP) >> RECIP_SH for x up to 2300
    localparam int RECIP         = 455910;
    localparam int RECIP_SH      = 20;
    localparam int SENS_PROD_W   = 31;
    localparam int WSUM_W        = 14;
    localparam int VSUM_W        = 12;
    localparam int MAG_W         = 20;
    localparam int QUO_W         = 10;
    localparam int REM_W         = 13;
    localparam int DIV_STEPS     = QUO_W;
    localparam int POS_W         = 21;
    localparam int LOST_POS_Q8   = 3000 * 256;
    localparam int SERR_W        = 24;
    localparam int SDIFF_W       = 25;
    localparam int SSUM_W        = 16;
    localparam int STEER_SUM_MAX = 30 * 256;
    localparam int GAIN_W        = 16;
    localparam int MUL_B_W       = 32;
    localparam int ACC_W         = 49;
    localparam int MUL_OPS       = 6;
    localparam int CORR_MAX      = 90 * 65536;
    localparam int APC_W         = 15;
    localparam int MIX_W         = 44;
    localparam int BASE_DUTY     = 50 * 256;
    localparam int ONE_DEG       = 256;
    localparam int EXIT_LOW      = -2 * 256;
    localparam int DUTY_W        = 15;
    localparam int PCT_W         = 7;
    localparam int STEP_W        = 4;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SENSE,
        ST_DIVIDE,
        ST_STEER,
        ST_MULT,
        ST_MIX
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SENSE,
        CMD_DIV,
        CMD_STEER,
        CMD_MULT,
        CMD_MIX
    } t_op;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        REG_PITCH_KP,
        REG_PITCH_KI,
        REG_PITCH_KD,
        REG_YAW_KP,
        REG_YAW_KI,
        REG_YAW_KD,
        REG_DUTY_FLOOR,
        REG_DUTY_CEILING
    } t_reg;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [GAIN_W-1:0] pitch_kp;
        logic [GAIN_W-1:0] pitch_ki;
        logic [GAIN_W-1:0] pitch_kd;
        logic [GAIN_W-1:0] yaw_kp;
        logic [GAIN_W-1:0] yaw_ki;
        logic [GAIN_W-1:0] yaw_kd;
        logic [PCT_W-1:0]  duty_floor;
        logic [PCT_W-1:0]  duty_ceiling;
    } t_cfg;

    // sensor weight 2*i - (SENSOR_COUNT-1)
    function automatic logic signed [4:0] sensor_weight(input logic [SIDX_W-1:0] idx);
        sensor_weight = 5'(2 * int'(idx) - (SENSOR_COUNT - 1));
    endfunction

endpackage

FILE: rtl/core/blfc_regs.sv
// ---------------------------------------------------------------------------
// blfc_regs
// configuration registers behind the apb-style port
// ---------------------------------------------------------------------------
module blfc_regs
    import blfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_reg addr_reg;

    assign pready   = 1'b1;
    assign addr_reg = t_reg'(paddr[PADDR_W-1:2]);
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_kp     <= GAIN_W'(1498);
            r_cfg.pitch_ki     <= GAIN_W'(24);
            r_cfg.pitch_kd     <= GAIN_W'(717);
            r_cfg.yaw_kp       <= GAIN_W'(512);
            r_cfg.yaw_ki       <= GAIN_W'(0);
            r_cfg.yaw_kd       <= GAIN_W'(192);
            r_cfg.duty_floor   <= PCT_W'(60);
            r_cfg.duty_ceiling <= PCT_W'(100);
        end else if (psel && penable && pwrite && pready) begin
            unique case (addr_reg)
                REG_PITCH_KP:     r_cfg.pitch_kp     <= pwdata[GAIN_W-1:0];
                REG_PITCH_KI:     r_cfg.pitch_ki     <= pwdata[GAIN_W-1:0];
                REG_PITCH_KD:     r_cfg.pitch_kd     <= pwdata[GAIN_W-1:0];
                REG_YAW_KP:       r_cfg.yaw_kp       <= pwdata[GAIN_W-1:0];
                REG_YAW_KI:       r_cfg.yaw_ki       <= pwdata[GAIN_W-1:0];
                REG_YAW_KD:       r_cfg.yaw_kd       <= pwdata[GAIN_W-1:0];
                REG_DUTY_FLOOR:   r_cfg.duty_floor   <= pwdata[PCT_W-1:0];
                REG_DUTY_CEILING: r_cfg.duty_ceiling <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr_reg)
            REG_PITCH_KP:     prdata = PDATA_W'(r_cfg.pitch_kp);
            REG_PITCH_KI:     prdata = PDATA_W'(r_cfg.pitch_ki);
            REG_PITCH_KD:     prdata = PDATA_W'(r_cfg.pitch_kd);
            REG_YAW_KP:       prdata = PDATA_W'(r_cfg.yaw_kp);
            REG_YAW_KI:       prdata = PDATA_W'(r_cfg.yaw_ki);
            REG_YAW_KD:       prdata = PDATA_W'(r_cfg.yaw_kd);
            REG_DUTY_FLOOR:   prdata = PDATA_W'(r_cfg.duty_floor);
            REG_DUTY_CEILING: prdata = PDATA_W'(r_cfg.duty_ceiling);
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/blfc_ctrl.sv
// ---------------------------------------------------------------------------
// blfc_ctrl
// sequencer: steps the datapath through sense, divide, steer, multiply, mix
// ---------------------------------------------------------------------------
module blfc_ctrl
    import blfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd.op   = CMD_NONE;
        o_cmd.step = r_step;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = ST_SENSE;
                    n_step   = '0;
                end
            end
            ST_SENSE: begin
                o_cmd.op = CMD_SENSE;
                if (r_step == STEP_W'(SENSOR_COUNT - 1)) begin
                    n_state = ST_DIVIDE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIVIDE: begin
                o_cmd.op = CMD_DIV;
                if (r_step == STEP_W'(DIV_STEPS)) begin
                    n_state = ST_STEER;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_STEER: begin
                o_cmd.op = CMD_STEER;
                n_state  = ST_MULT;
                n_step   = '0;
            end
            ST_MULT: begin
                o_cmd.op = CMD_MULT;
                if (r_step == STEP_W'(MUL_OPS)) begin
                    n_state = ST_MIX;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MIX: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_MIX;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/blfc_dp.sv
// ---------------------------------------------------------------------------
// blfc_dp
// datapath: sensor scaling, position divider, shared multiplier, mixing
// ---------------------------------------------------------------------------
module blfc_dp
    import blfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_cfg                 i_cfg,
    output t_status              o_status,
    input  logic signed [15:0]   i_tilt_angle,
    input  logic [ADC_BITS-1:0]  i_line_raw_0,
    input  logic [ADC_BITS-1:0]  i_line_raw_1,
    input  logic [ADC_BITS-1:0]  i_line_raw_2,
    input  logic [ADC_BITS-1:0]  i_line_raw_3,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [DUTY_W-1:0]    o_left_duty,
    output logic [DUTY_W-1:0]    o_right_duty,
    output logic [1:0]           o_motor_direction,
    output logic                 o_use_forward_reference,
    output logic                 o_line_lost
);

    // item registers
    logic signed [15:0]         r_tilt;
    logic [ADC_BITS-1:0]        r_raw [SENSOR_COUNT];
    // controller state
    logic signed [15:0]         r_last_tilt;
    logic signed [31:0]         r_tsum;
    logic signed [SERR_W-1:0]   r_last_steer;
    logic signed [SSUM_W-1:0]   r_ssum;
    logic                       r_bal;
    // working registers
    logic signed [16:0]         r_pdiff;
    t_dir                       r_dir;
    logic signed [WSUM_W-1:0]   r_wsum;
    logic [VSUM_W-1:0]          r_vsum;
    logic                       r_lost;
    logic [REM_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_dq;
    logic                       r_neg;
    logic signed [SERR_W-1:0]   r_serr;
    logic signed [SDIFF_W-1:0]  r_sdiff;
    logic signed [ACC_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]    r_pacc;
    logic signed [ACC_W-1:0]    r_yacc;
    // output register
    logic                       r_out_valid;
    logic [DUTY_W-1:0]          r_left, r_right;
    t_dir                       r_out_dir;
    logic                       r_out_fwd, r_out_lost;

    // sensor scaling
    logic [SIDX_W-1:0]          sens_idx;
    logic [ADC_BITS-1:0]        sens_raw, sens_clip, sens_x;
    logic [SENS_PROD_W-1:0]     sens_prod;
    logic [VAL_W-1:0]           sens_v;
    logic signed [WSUM_W-1:0]   sens_wv;
    // pitch step
    logic signed [32:0]         psum_wide;
    logic signed [31:0]         psum_sat;
    logic                       psign_chg;
    t_dir                       dir_next;
    logic                       bal_next;
    // divider
    logic [MAG_W-1:0]           div_mag;
    logic [REM_W-1:0]           div_trial;
    logic                       div_ge;
    // steering
    logic signed [POS_W-1:0]    pos;
    logic signed [SERR_W-1:0]   serr;
    logic signed [SDIFF_W:0]    ssum_wide;
    logic signed [SSUM_W-1:0]   ssum_clip;
    // multiplier
    logic [GAIN_W-1:0]          mul_gain;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    pint_clip;
    // mixing
    logic signed [ACC_W-1:0]    pabs, pclip;
    logic [APC_W-1:0]           apc;
    logic signed [ACC_W-1:0]    ybias;
    logic signed [MIX_W-1:0]    ycorr, yterm, common, left_raw, right_raw, lo, hi;
    logic [DUTY_W-1:0]          left_clip, right_clip;

    assign o_status.out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid             = r_out_valid;
    assign o_left_duty             = r_left;
    assign o_right_duty            = r_right;
    assign o_motor_direction       = r_out_dir;
    assign o_use_forward_reference = r_out_fwd;
    assign o_line_lost             = r_out_lost;

    // one sensor per step
    always_comb begin
        sens_idx  = i_cmd.step[SIDX_W-1:0];
        sens_raw  = r_raw[sens_idx];
        if (sens_raw < ADC_BITS'(RAW_LOW)) begin
            sens_clip = ADC_BITS'(RAW_LOW);
        end else if (sens_raw > ADC_BITS'(RAW_HIGH)) begin
            sens_clip = ADC_BITS'(RAW_HIGH);
        end else begin
            sens_clip = sens_raw;
        end
        sens_x    = sens_clip - ADC_BITS'(RAW_LOW);
        sens_prod = SENS_PROD_W'(sens_x) * SENS_PROD_W'(RECIP);
        sens_v    = sens_prod[RECIP_SH +: VAL_W];
        sens_wv   = WSUM_W'($signed({1'b0, sens_v})) * WSUM_W'(sensor_weight(sens_idx));
    end

    // pitch sum and balance state
    always_comb begin
        psum_wide = 33'(r_tsum) + 33'(r_tilt);
        if (psum_wide[32] != psum_wide[31]) begin
            psum_sat = psum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            psum_sat = psum_wide[31:0];
        end
        psign_chg = (r_tilt > 0 && r_last_tilt < 0) || (r_tilt < 0 && r_last_tilt > 0);
        bal_next  = r_bal;
        if (!r_bal) begin
            if (r_tilt > 16'(ONE_DEG)) begin
                dir_next = DIR_FWD;
            end else if (r_tilt < -16'(ONE_DEG)) begin
                dir_next = DIR_BWD;
            end else begin
                dir_next = DIR_STOP;
                bal_next = 1'b1;
            end
        end else begin
            if (r_tilt > 0) begin
                dir_next = DIR_FWD;
            end else if (r_tilt < 0) begin
                dir_next = DIR_BWD;
            end else begin
                dir_next = DIR_STOP;
            end
            if (r_tilt > 16'(ONE_DEG) || r_tilt < 16'(EXIT_LOW)) begin
                bal_next = 1'b0;
            end
        end
    end

    // restoring divider step
    always_comb begin
        div_mag   = r_wsum[WSUM_W-1] ? MAG_W'(-32'(r_wsum)) << 8 : MAG_W'(32'(r_wsum)) << 8;
        div_trial = {r_rem[REM_W-2:0], r_dq[QUO_W-1]};
        div_ge    = (div_trial >= REM_W'(r_vsum));
    end

    // position and steering error
    always_comb begin
        if (r_lost) begin
            pos = (r_last_steer > 0) ? POS_W'(LOST_POS_Q8) : -POS_W'(LOST_POS_Q8);
        end else if (r_neg) begin
            pos = -POS_W'(r_dq);
        end else begin
            pos = POS_W'(r_dq);
        end
        serr      = SERR_W'(pos) * SERR_W'(10);
        ssum_wide = (SDIFF_W + 1)'(r_ssum) + (SDIFF_W + 1)'(serr);
        if (ssum_wide > (SDIFF_W + 1)'(STEER_SUM_MAX)) begin
            ssum_clip = SSUM_W'(STEER_SUM_MAX);
        end else if (ssum_wide < -(SDIFF_W + 1)'(STEER_SUM_MAX)) begin
            ssum_clip = -SSUM_W'(STEER_SUM_MAX);
        end else begin
            ssum_clip = ssum_wide[SSUM_W-1:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (i_cmd.step)
            4'd0: begin
                mul_gain = i_cfg.pitch_ki;
                mul_b    = r_tsum;
            end
            4'd1: begin
                mul_gain = i_cfg.pitch_kp;
                mul_b    = MUL_B_W'(r_tilt);
            end
            4'd2: begin
                mul_gain = i_cfg.pitch_kd;
                mul_b    = MUL_B_W'(r_pdiff);
            end
            4'd3: begin
                mul_gain = i_cfg.yaw_kp;
                mul_b    = MUL_B_W'(r_serr);
            end
            4'd4: begin
                mul_gain = i_cfg.yaw_ki;
                mul_b    = MUL_B_W'(r_ssum);
            end
            4'd5: begin
                mul_gain = i_cfg.yaw_kd;
                mul_b    = MUL_B_W'(r_sdiff);
            end
            default: begin
                mul_gain = '0;
                mul_b    = '0;
            end
        endcase
        if (r_prod > ACC_W'(CORR_MAX)) begin
            pint_clip = ACC_W'(CORR_MAX);
        end else if (r_prod < -ACC_W'(CORR_MAX)) begin
            pint_clip = -ACC_W'(CORR_MAX);
        end else begin
            pint_clip = r_prod;
        end
    end

    // mixing and duty clamp
    always_comb begin
        pabs   = (r_pacc < 0) ? -r_pacc : r_pacc;
        pclip  = (pabs > ACC_W'(CORR_MAX)) ? ACC_W'(CORR_MAX) : pabs;
        apc    = pclip[8 +: APC_W];
        ybias  = r_yacc + ((r_yacc < 0) ? ACC_W'(255) : ACC_W'(0));
        ycorr  = MIX_W'(ybias >>> 8);
        yterm  = (r_tilt > 0) ? ycorr : -ycorr;
        common = MIX_W'($signed({1'b0, apc})) + MIX_W'(BASE_DUTY);
        left_raw  = common + yterm;
        right_raw = common - yterm;
        lo = MIX_W'($signed({1'b0, i_cfg.duty_floor, 8'd0}));
        hi = MIX_W'($signed({1'b0, i_cfg.duty_ceiling, 8'd0}));
        priority if (left_raw < lo) left_clip = DUTY_W'(lo);
        else if (left_raw > hi)     left_clip = DUTY_W'(hi);
        else                        left_clip = DUTY_W'(left_raw);
        priority if (right_raw < lo) right_clip = DUTY_W'(lo);
        else if (right_raw > hi)     right_clip = DUTY_W'(hi);
        else                         right_clip = DUTY_W'(right_raw);
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tilt  <= '0;
            r_tsum       <= '0;
            r_last_steer <= '0;
            r_ssum       <= '0;
            r_bal        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == CMD_SENSE && i_cmd.step == '0) begin
                r_tsum      <= psign_chg ? 32'sd0 : psum_sat;
                r_last_tilt <= r_tilt;
                r_bal       <= bal_next;
            end
            if (i_cmd.op == CMD_STEER) begin
                r_last_steer <= serr;
                r_ssum       <= ssum_clip;
            end
            if (i_cmd.op == CMD_MIX) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_tilt   <= i_tilt_angle;
                r_raw[0] <= i_line_raw_0;
                r_raw[1] <= i_line_raw_1;
                r_raw[2] <= i_line_raw_2;
                r_raw[3] <= i_line_raw_3;
                r_wsum   <= '0;
                r_vsum   <= '0;
                r_lost   <= 1'b1;
            end
            CMD_SENSE: begin
                r_wsum <= r_wsum + sens_wv;
                r_vsum <= r_vsum + VSUM_W'(sens_v);
                if (sens_v > VAL_W'(SEEN_LEVEL)) begin
                    r_lost <= 1'b0;
                end
                if (i_cmd.step == '0) begin
                    r_pdiff <= 17'(r_tilt) - 17'(r_last_tilt);
                    r_dir   <= dir_next;
                end
            end
            CMD_DIV: begin
                if (i_cmd.step == '0) begin
                    r_rem <= REM_W'(div_mag[MAG_W-1:QUO_W]);
                    r_dq  <= div_mag[QUO_W-1:0];
                    r_neg <= r_wsum[WSUM_W-1];
                end else begin
                    r_rem <= div_ge ? div_trial - REM_W'(r_vsum) : div_trial;
                    r_dq  <= {r_dq[QUO_W-2:0], div_ge};
                end
            end
            CMD_STEER: begin
                r_serr  <= serr;
                r_sdiff <= SDIFF_W'(serr) - SDIFF_W'(r_last_steer);
            end
            CMD_MULT: begin
                r_prod <= ACC_W'($signed({1'b0, mul_gain})) * ACC_W'(mul_b);
                unique case (i_cmd.step)
                    4'd1:    r_pacc <= pint_clip;
                    4'd2:    r_pacc <= r_pacc + r_prod;
                    4'd3:    r_pacc <= r_pacc + r_prod;
                    4'd4:    r_yacc <= r_prod;
                    4'd5:    r_yacc <= r_yacc + r_prod;
                    4'd6:    r_yacc <= r_yacc + r_prod;
                    default: ;
                endcase
            end
            CMD_MIX: begin
                r_left     <= left_clip;
                r_right    <= right_clip;
                r_out_dir  <= r_dir;
                r_out_fwd  <= r_bal;
                r_out_lost <= r_lost;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/balance_line_follow_controller_unit.sv
// ---------------------------------------------------------------------------
// balance_line_follow_controller_unit
// pitch pid balance with line position steering, fixed point
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         i_in_valid / o_in_stall tilt angle, four line readings
// output    out        o_out_valid / i_out_stall duties, direction, flags
// config    in         psel/penable/pwrite     eight gain and duty registers
//
// a transaction runs load, 4 sensor steps, 11 divider steps for the line
// position, steer, 7 steps on one shared 17x32 multiplier, then mix
// a finished result sits in the output register while the next item runs
// o_in_stall is high from acceptance until the result is loaded
// synchronous active-low reset restores register defaults and clears state
// ---------------------------------------------------------------------------
module balance_line_follow_controller_unit
    import blfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_tilt_angle,
    input  logic [ADC_BITS-1:0] i_line_raw_0,
    input  logic [ADC_BITS-1:0] i_line_raw_1,
    input  logic [ADC_BITS-1:0] i_line_raw_2,
    input  logic [ADC_BITS-1:0] i_line_raw_3,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DUTY_W-1:0]   o_left_duty,
    output logic [DUTY_W-1:0]   o_right_duty,
    output logic [1:0]          o_motor_direction,
    output logic                o_use_forward_reference,
    output logic                o_line_lost,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    blfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    blfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    blfc_dp u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .i_cfg                   (cfg),
        .o_status                (status),
        .i_tilt_angle            (i_tilt_angle),
        .i_line_raw_0            (i_line_raw_0),
        .i_line_raw_1            (i_line_raw_1),
        .i_line_raw_2            (i_line_raw_2),
        .i_line_raw_3            (i_line_raw_3),
        .i_out_stall             (i_out_stall),
        .o_out_valid             (o_out_valid),
        .o_left_duty             (o_left_duty),
        .o_right_duty            (o_right_duty),
        .o_motor_direction       (o_motor_direction),
        .o_use_forward_reference (o_use_forward_reference),
        .o_line_lost             (o_line_lost)
    );

endmodule

FILE: rtl/core/blfc_checker.sv
// ---------------------------------------------------------------------------
// blfc_checker
// port-level checks of the controller, bound to the top level
// ---------------------------------------------------------------------------
`include "balance_line_follow_controller_unit_macros.svh"

module blfc_checker
    import blfc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DUTY_W-1:0]  o_left_duty,
    input logic [DUTY_W-1:0]  o_right_duty,
    input logic [1:0]         o_motor_direction
);

    `BLFC_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `BLFC_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "no stall after accept")
    `BLFC_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_duty)), "stalled result changed")
    `BLFC_ASSERT(a_duty_range, o_out_valid |-> (o_left_duty <= 15'd32512 && o_right_duty <= 15'd32512), "duty out of range")
    `BLFC_ASSERT(a_dir_code, o_out_valid |-> (o_motor_direction != 2'd3), "bad motor direction")

endmodule

bind balance_line_follow_controller_unit blfc_checker u_blfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_left_duty       (o_left_duty),
    .o_right_duty      (o_right_duty),
    .o_motor_direction (o_motor_direction)
);

FILE: tb/sv/tb_balance_line_follow_controller_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_balance_line_follow_controller_unit
// self-checking regression of the balance and line follow controller
// ---------------------------------------------------------------------------
// a class-based predictor tracks the pitch and steering loops and the
// balance state; every transaction accepted on the input notes one expected
// result, every output transaction is checked field by field in order.
// gains and duty limits are written over apb between phases, including
// extremes, with random idle gaps on both sides and one long output hold-off
// ---------------------------------------------------------------------------
module tb_balance_line_follow_controller_unit;
    import blfc_pkg::*;

    typedef struct {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        t_dir              direction;
        logic              fwd_ref;
        logic              lost;
    } t_motor_cmd;

    class controller_scoreboard;
        t_motor_cmd     pending[$];
        int             mismatches;
        logic [15:0]    gain[6];
        logic [6:0]     floor_pct;
        logic [6:0]     ceil_pct;
        int             prev_tilt;
        longint         tilt_sum;
        longint         prev_steer;
        longint         steer_sum;
        bit             balanced;

        function new();
            gain = '{16'd1498, 16'd24, 16'd717, 16'd512, 16'd0, 16'd192};
            floor_pct = 7'd60;
            ceil_pct = 7'd100;
            prev_tilt = 0;
            tilt_sum = 0;
            prev_steer = 0;
            steer_sum = 0;
            balanced = 0;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg r, logic [31:0] v);
            if (r == REG_DUTY_FLOOR) begin
                floor_pct = v[6:0];
            end else if (r == REG_DUTY_CEILING) begin
                ceil_pct = v[6:0];
            end else begin
                gain[int'(r)] = v[15:0];
            end
        endfunction

        function longint level(logic [11:0] raw);
            longint r;
            r = raw;
            if (r < 1700) r = 1700;
            if (r > 4000) r = 4000;
            return ((r - 1700) * 1000) / 2300;
        endfunction

        function void note_input(logic signed [15:0] tilt, logic [11:0] raw[4]);
            t_motor_cmd c;
            longint err, s, integ, corr, apc, wsum, vsum, v, pos, serr, ycorr;
            longint left, right, lo, hi, mix;
            bit lost;
            err = tilt;
            s = tilt_sum + err;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            if ((err > 0 && prev_tilt < 0) || (err < 0 && prev_tilt > 0)) s = 0;
            tilt_sum = s;
            integ = s * longint'(gain[1]);
            if (integ > (64'sd90 << 16)) integ = 64'sd90 << 16;
            if (integ < -(64'sd90 << 16)) integ = -(64'sd90 << 16);
            corr = longint'(gain[0]) * err + integ + longint'(gain[2]) * (err - prev_tilt);
            prev_tilt = err;
            if (corr < 0) corr = -corr;
            if (corr > (64'sd90 << 16)) corr = 64'sd90 << 16;
            apc = corr >>> 8;
            wsum = 0;
            vsum = 0;
            lost = 1;
            for (int i = 0; i < 4; i++) begin
                v = level(raw[i]);
                if (v > 400) lost = 0;
                wsum += v * (2 * i - 3);
                vsum += v;
            end
            pos = (vsum != 0) ? (wsum * 256) / vsum : 0;
            if (lost) pos = (prev_steer > 0) ? 3000 * 256 : -3000 * 256;
            serr = pos * 10;
            steer_sum = steer_sum + serr;
            if (steer_sum > 30 * 256) steer_sum = 30 * 256;
            if (steer_sum < -30 * 256) steer_sum = -30 * 256;
            ycorr = longint'(gain[3]) * serr + longint'(gain[4]) * steer_sum
                  + longint'(gain[5]) * (serr - prev_steer);
            ycorr = ycorr / 256;
            prev_steer = serr;
            mix = (err > 0) ? ycorr : -ycorr;
            left = apc + 50 * 256 + mix;
            right = apc + 50 * 256 - mix;
            lo = longint'(floor_pct) * 256;
            hi = longint'(ceil_pct) * 256;
            left = (left < lo) ? lo : ((left > hi) ? hi : left);
            right = (right < lo) ? lo : ((right > hi) ? hi : right);
            if (!balanced) begin
                if (err > 256) c.direction = DIR_FWD;
                else if (err < -256) c.direction = DIR_BWD;
                else begin
                    c.direction = DIR_STOP;
                    balanced = 1;
                end
            end else begin
                if (err > 0) c.direction = DIR_FWD;
                else if (err < 0) c.direction = DIR_BWD;
                else c.direction = DIR_STOP;
                if (err > 256 || err < -512) balanced = 0;
            end
            c.left_duty = left[14:0];
            c.right_duty = right[14:0];
            c.fwd_ref = balanced;
            c.lost = lost;
            pending.push_back(c);
        endfunction

        function void check_result(t_motor_cmd got);
            t_motor_cmd e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
                return;
            end
            e = pending.pop_front();
            if (got.left_duty !== e.left_duty || got.right_duty !== e.right_duty
                    || got.direction !== e.direction || got.fwd_ref !== e.fwd_ref
                    || got.lost !== e.lost) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp l=%0d r=%0d d=%0d f=%0b n=%0b got l=%0d r=%0d d=%0d f=%0b n=%0b",
                        e.left_duty, e.right_duty, e.direction, e.fwd_ref, e.lost,
                        got.left_duty, got.right_duty, got.direction, got.fwd_ref, got.lost);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic signed [15:0]  i_tilt_angle;
    logic [11:0]         i_line_raw_0, i_line_raw_1, i_line_raw_2, i_line_raw_3;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [DUTY_W-1:0]   o_left_duty, o_right_duty;
    logic [1:0]          o_motor_direction;
    logic                o_use_forward_reference, o_line_lost;
    logic                psel, penable, pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata, prdata;
    logic                pready;

    controller_scoreboard board;
    int  hold_off;
    int  out_wait;
    bit  sending_done;

    balance_line_follow_controller_unit i_dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic write_reg(t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(4 * int'(r));
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_reg(r, v);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(logic signed [15:0] tilt, logic [11:0] a, logic [11:0] b,
                             logic [11:0] c, logic [11:0] d, bit gaps);
        logic [11:0] raw[4];
        int idle;
        idle = gaps ? $urandom_range(0, 13) : 0;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tilt_angle <= tilt;
        i_line_raw_0 <= a;
        i_line_raw_1 <= b;
        i_line_raw_2 <= c;
        i_line_raw_3 <= d;
        raw = '{a, b, c, d};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(tilt, raw);
        @(negedge i_clk);
    endtask

    function automatic logic [11:0] rand_raw();
        case ($urandom_range(0, 4))
            0: return 12'($urandom_range(0, 1700));
            1: return 12'($urandom_range(3990, 4095));
            default: return 12'($urandom_range(1600, 4095));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_tilt();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 1200)) - 600);
            2: return 16'(int'($urandom_range(0, 46080)) - 23040);
            default: return 16'(int'($urandom_range(0, 6000)) - 3000);
        endcase
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
            send_item(rand_tilt(), rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                      $urandom_range(0, 3) != 0);
    endtask

    // output side: a drawn wait before each transaction, and one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait = out_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_motor_cmd got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.left_duty = o_left_duty;
            got.right_duty = o_right_duty;
            got.direction = t_dir'(o_motor_direction);
            got.fwd_ref = o_use_forward_reference;
            got.lost = o_line_lost;
            board.check_result(got);
            out_wait = sending_done ? 0 : $urandom_range(0, 13);
        end
    end

    initial begin
        #20000000;
        $display("balance_line_follow_controller_unit regression: fail");
        $finish;
    end

    initial begin
        board = new();
        hold_off = 0;
        out_wait = 0;
        sending_done = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_tilt_angle = '0;
        i_line_raw_0 = '0;
        i_line_raw_1 = '0;
        i_line_raw_2 = '0;
        i_line_raw_3 = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, line lost, sign change, balance entry and exit
        send_item(16'sd0, 12'd0, 12'd0, 12'd0, 12'd0, 0);
        send_item(16'sd23040, 12'd4095, 12'd0, 12'd0, 12'd0, 0);
        send_item(-16'sd23040, 12'd0, 12'd0, 12'd0, 12'd4095, 0);
        send_item(16'sd100, 12'd2500, 12'd2500, 12'd2500, 12'd2500, 0);
        send_item(16'sd0, 12'd0, 12'd0, 12'd0, 12'd0, 0);
        send_item(16'sd200, 12'd1700, 12'd4000, 12'd1700, 12'd1700, 0);
        send_item(-16'sd300, 12'd1700, 12'd1700, 12'd4000, 12'd1700, 0);
        send_item(-16'sd600, 12'd2620, 12'd2620, 12'd1700, 12'd1700, 0);
        send_item(16'sd257, 12'd2621, 12'd0, 12'd0, 12'd0, 0);
        send_item(-16'sd256, 12'd1701, 12'd1701, 12'd0, 12'd0, 0);
        send_item(16'sh7fff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 0);
        send_item(16'sh8000, 12'h555, 12'haaa, 12'h555, 12'haaa, 0);
        send_item(16'sd256, 12'd3000, 12'd0, 12'd0, 12'd3000, 0);
        send_item(-16'sd512, 12'd0, 12'd3000, 12'd3000, 12'd0, 0);
        send_item(-16'sd513, 12'd0, 12'd0, 12'd0, 12'd0, 0);
        drain();

        // integrator saturation and inverted duty limits
        write_reg(REG_PITCH_KI, 32'hffff);
        write_reg(REG_YAW_KI, 32'hffff);
        write_reg(REG_DUTY_FLOOR, 32'd90);
        write_reg(REG_DUTY_CEILING, 32'd40);
        for (int k = 0; k < 8; k++)
            send_item(16'sh7fff, 12'd4000, 12'd0, 12'd0, 12'd0, 0);
        random_phase(150);
        drain();

        write_reg(REG_PITCH_KP, 32'd0);
        write_reg(REG_PITCH_KI, 32'd0);
        write_reg(REG_PITCH_KD, 32'd0);
        write_reg(REG_YAW_KP, 32'd0);
        write_reg(REG_YAW_KI, 32'd0);
        write_reg(REG_YAW_KD, 32'd0);
        write_reg(REG_DUTY_FLOOR, 32'd0);
        write_reg(REG_DUTY_CEILING, 32'd127);
        random_phase(150);
        drain();

        write_reg(REG_PITCH_KP, 32'hffff);
        write_reg(REG_PITCH_KD, 32'hffff);
        write_reg(REG_YAW_KP, 32'hffff);
        write_reg(REG_YAW_KD, 32'hffff);
        write_reg(REG_DUTY_FLOOR, 32'd127);
        write_reg(REG_DUTY_CEILING, 32'd0);
        random_phase(150);
        drain();

        // long output hold-off while input keeps coming
        write_reg(REG_PITCH_KP, 32'd1498);
        write_reg(REG_PITCH_KI, 32'd24);
        write_reg(REG_PITCH_KD, 32'd717);
        write_reg(REG_YAW_KP, 32'd512);
        write_reg(REG_YAW_KI, 32'd3);
        write_reg(REG_YAW_KD, 32'd192);
        write_reg(REG_DUTY_FLOOR, 32'd60);
        write_reg(REG_DUTY_CEILING, 32'd100);
        @(negedge i_clk);
        hold_off <= 300;
        random_phase(200);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_PITCH_KP, 32'($urandom_range(0, 65535)));
            write_reg(REG_PITCH_KI, 32'($urandom_range(0, 300)));
            write_reg(REG_PITCH_KD, 32'($urandom_range(0, 65535)));
            write_reg(REG_YAW_KP, 32'($urandom_range(0, 2000)));
            write_reg(REG_YAW_KI, 32'($urandom_range(0, 65535)));
            write_reg(REG_YAW_KD, 32'($urandom_range(0, 2000)));
            write_reg(REG_DUTY_FLOOR, 32'($urandom_range(0, 70)));
            write_reg(REG_DUTY_CEILING, 32'($urandom_range(50, 127)));
            random_phase(200);
            drain();
        end

        sending_done = 1;
        drain();
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("balance_line_follow_controller_unit regression: pass");
        end else begin
            $display("balance_line_follow_controller_unit regression: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/blfc_pkg.sv
rtl/core/blfc_regs.sv
rtl/core/blfc_ctrl.sv
rtl/core/blfc_dp.sv
rtl/core/balance_line_follow_controller_unit.sv
rtl/core/blfc_checker.sv
tb/sv/tb_balance_line_follow_controller_unit.sv
